// ===== sv/ibc_pkg.sv =====
// ============================================================================
// ibc_pkg
// Shared types and constants of the IMU bias calibration block.
// ============================================================================
package ibc_pkg;

    localparam int IN_W             = 16;
    localparam int WORD_W           = 16;
    localparam int N_AXES           = 6;
    localparam int N_ACCEL          = 3;
    localparam int SAMPLE_COUNT_DEF = 20;

    // Dividend width of the divider lanes: holds the magnitude of a full sum
    // (up to 64 frames) and the scaled gyro average |avg| * 32.
    localparam int DIV_W  = 22;
    // A divide by a constant is a multiply by its rounded-up reciprocal
    // scaled by 2^RECIP_SHIFT; exact for any dividend below 2^DIV_W and any
    // divisor up to 131.
    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_W     = 31;

    localparam logic [WORD_W-1:0] ONE_G      = 16'h4000;
    localparam int                GYRO_SHIFT = 5;    // times 32
    localparam int                GYRO_DIV   = 131;
    localparam logic [RECIP_W-1:0] GYRO_RECIP =
        RECIP_W'(((longint'(1) << RECIP_SHIFT) + longint'(GYRO_DIV - 1)) / longint'(GYRO_DIV));

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FACTORY_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FACTORY_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FACTORY_Z = 2'd2;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_LOAD1,
        ST_DIV1,
        ST_LOAD2,
        ST_DIV2,
        ST_FIN
    } ibc_state_t;

    typedef struct packed {
        logic acc;       // add the accepted frame to the sums
        logic load1;     // load lanes with |sum|, clear sums and count
        logic load2;     // capture averages, load gyro lanes with |avg|*32
        logic step;      // one reciprocal multiply on all lanes
        logic sel2;      // reciprocal select: gyro scale divisor
        logic res_load;  // build offset words into the output register
    } ibc_cmd_t;

    typedef struct packed {
        logic last_frame;  // the next accepted frame completes the batch
    } ibc_status_t;

endpackage

// ===== sv/ibc_div_lane.sv =====
// ============================================================================
// ibc_div_lane
// Divide-by-constant lane: registered operand times a scaled reciprocal.
// ============================================================================
module ibc_div_lane #(
    parameter int DATA_W  = ibc_pkg::DIV_W,
    parameter int RECIP_W = ibc_pkg::RECIP_W,
    parameter int SHIFT   = ibc_pkg::RECIP_SHIFT
) (
    input  logic               clk,
    input  logic               load,
    input  logic               step,
    input  logic [DATA_W-1:0]  dividend,
    input  logic [RECIP_W-1:0] recip,
    output logic [DATA_W-1:0]  quotient
);

    localparam int PROD_W = DATA_W + RECIP_W;

    logic [DATA_W-1:0] opnd_reg;
    logic [DATA_W-1:0] opnd_next;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    always_comb
    begin
        opnd_next = opnd_reg;
        prod_next = prod_reg;
        if (load)
            opnd_next = dividend;
        else if (step)
            prod_next = PROD_W'(opnd_reg) * PROD_W'(recip);
    end

    always_ff @(posedge clk)
    begin
        opnd_reg <= opnd_next;
        prod_reg <= prod_next;
    end

    assign quotient = prod_reg[SHIFT +: DATA_W];

endmodule

// ===== sv/ibc_datapath.sv =====
// ============================================================================
// ibc_datapath
// Axis sums, frame counter, six divider lanes and offset word formatting.
// ============================================================================
module ibc_datapath #(
    parameter int SAMPLE_COUNT = ibc_pkg::SAMPLE_COUNT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ibc_pkg::ibc_cmd_t                cmd,
    output ibc_pkg::ibc_status_t             status,
    input  logic                             cfg_we,
    input  logic [ibc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ibc_pkg::WORD_W-1:0]       cfg_data,
    input  logic signed [ibc_pkg::IN_W-1:0]  frame [ibc_pkg::N_AXES],
    output logic [ibc_pkg::WORD_W-1:0]       result [ibc_pkg::N_AXES]
);

    localparam int SUM_W = ibc_pkg::IN_W + $clog2(SAMPLE_COUNT);
    localparam int CNT_W = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLE_COUNT - 1);
    localparam logic [ibc_pkg::RECIP_W-1:0] BATCH_RECIP =
        ibc_pkg::RECIP_W'(((longint'(1) << ibc_pkg::RECIP_SHIFT) + longint'(SAMPLE_COUNT - 1))
                          / longint'(SAMPLE_COUNT));
    localparam int W  = ibc_pkg::WORD_W;
    localparam int NA = ibc_pkg::N_AXES;

    logic signed [SUM_W-1:0]       sums_reg [NA];
    logic signed [SUM_W-1:0]       sums_next [NA];
    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              cnt_next;
    logic [W-1:0]                  factory_reg [ibc_pkg::N_ACCEL];
    logic [NA-1:0]                 neg_reg;
    logic [NA-1:0]                 neg_next;
    logic [W-1:0]                  accel_avg_reg [ibc_pkg::N_ACCEL];
    logic [W-1:0]                  accel_avg_next [ibc_pkg::N_ACCEL];
    logic [W-1:0]                  result_reg [NA];
    logic [W-1:0]                  result_next [NA];
    logic [ibc_pkg::DIV_W-1:0]     dividend [NA];
    logic [ibc_pkg::DIV_W-1:0]     quotient [NA];
    logic [ibc_pkg::RECIP_W-1:0]   recip;
    logic [W-1:0]                  avg [NA];

    assign status.last_frame = (cnt_reg == CNT_LAST);
    assign recip = cmd.sel2 ? ibc_pkg::GYRO_RECIP : BATCH_RECIP;

    // Sums and frame counter
    always_comb
    begin
        cnt_next = cnt_reg;
        for (int i = 0; i < NA; i++)
            sums_next[i] = sums_reg[i];
        if (cmd.load1)
        begin
            cnt_next = '0;
            for (int i = 0; i < NA; i++)
                sums_next[i] = '0;
        end
        else if (cmd.acc)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            for (int i = 0; i < NA; i++)
                sums_next[i] = sums_reg[i] + SUM_W'(frame[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            for (int i = 0; i < NA; i++)
                sums_reg[i] <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            for (int i = 0; i < NA; i++)
                sums_reg[i] <= sums_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ibc_pkg::N_ACCEL; i++)
                factory_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ibc_pkg::REG_FACTORY_X: factory_reg[0] <= cfg_data;
                ibc_pkg::REG_FACTORY_Y: factory_reg[1] <= cfg_data;
                ibc_pkg::REG_FACTORY_Z: factory_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Signed averages from sign and lane quotient (|avg| <= 32768)
    always_comb
    begin
        for (int i = 0; i < NA; i++)
            avg[i] = neg_reg[i] ? (W'(0) - quotient[i][W-1:0]) : quotient[i][W-1:0];
    end

    // Lane operands: |sum| first, then |avg| * 32 on the gyro lanes
    always_comb
    begin
        logic signed [ibc_pkg::DIV_W-1:0] sum_ext;
        neg_next = neg_reg;
        for (int i = 0; i < NA; i++)
        begin
            sum_ext = ibc_pkg::DIV_W'(sums_reg[i]);
            dividend[i] = '0;
            if (cmd.load1)
            begin
                neg_next[i] = sum_ext[ibc_pkg::DIV_W-1];
                dividend[i] = sum_ext[ibc_pkg::DIV_W-1] ? (ibc_pkg::DIV_W'(0) - sum_ext)
                                                        : sum_ext;
            end
            else if (i >= ibc_pkg::N_ACCEL)
            begin
                dividend[i] = ibc_pkg::DIV_W'({quotient[i][W-1:0],
                                               ibc_pkg::GYRO_SHIFT'(0)});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load1)
            neg_reg <= neg_next;
    end

    for (genvar g = 0; g < NA; g++)
    begin : g_lane
        ibc_div_lane #(
            .DATA_W  (ibc_pkg::DIV_W),
            .RECIP_W (ibc_pkg::RECIP_W),
            .SHIFT   (ibc_pkg::RECIP_SHIFT)
        ) u_lane (
            .clk      (clk),
            .load     (cmd.load1 | cmd.load2),
            .step     (cmd.step),
            .dividend (dividend[g]),
            .recip    (recip),
            .quotient (quotient[g])
        );
    end

    // Accel averages, with 1 g taken out of z toward zero
    always_comb
    begin
        for (int i = 0; i < ibc_pkg::N_ACCEL; i++)
            accel_avg_next[i] = avg[i];
        if ($signed(avg[2]) > $signed(W'(0)))
            accel_avg_next[2] = avg[2] - ibc_pkg::ONE_G;
        else
            accel_avg_next[2] = avg[2] + ibc_pkg::ONE_G;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load2)
        begin
            for (int i = 0; i < ibc_pkg::N_ACCEL; i++)
                accel_avg_reg[i] <= accel_avg_next[i];
        end
    end

    // Offset words
    always_comb
    begin
        logic [W-1:0] diff;
        logic [W-1:0] g;
        for (int i = 0; i < ibc_pkg::N_ACCEL; i++)
        begin
            diff = factory_reg[i] - W'($signed(accel_avg_reg[i]) >>> 3);
            result_next[i] = {diff[W-1:1], factory_reg[i][0]};
        end
        for (int i = ibc_pkg::N_ACCEL; i < NA; i++)
        begin
            // offset = -(avg*32/131): the sign flips against the average
            g = neg_reg[i] ? quotient[i][W-1:0] : (W'(0) - quotient[i][W-1:0]);
            result_next[i] = {g[W-1:1], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            for (int i = 0; i < NA; i++)
                result_reg[i] <= result_next[i];
        end
    end

    assign result = result_reg;

endmodule

// ===== sv/ibc_ctrl.sv =====
// ============================================================================
// ibc_ctrl
// Sequencer: accumulate frames, run two divider passes, hand off the result.
// ============================================================================
module ibc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  ibc_pkg::ibc_status_t status,
    output ibc_pkg::ibc_cmd_t    cmd
);

    ibc_pkg::ibc_state_t         state_reg;
    ibc_pkg::ibc_state_t         state_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ibc_pkg::ST_ACCUM:
                if (in_valid && status.last_frame)
                    state_next = ibc_pkg::ST_LOAD1;
            ibc_pkg::ST_LOAD1:
                state_next = ibc_pkg::ST_DIV1;
            ibc_pkg::ST_DIV1:
                state_next = ibc_pkg::ST_LOAD2;
            ibc_pkg::ST_LOAD2:
                state_next = ibc_pkg::ST_DIV2;
            ibc_pkg::ST_DIV2:
                state_next = ibc_pkg::ST_FIN;
            ibc_pkg::ST_FIN:
                if (out_free)
                    state_next = ibc_pkg::ST_ACCUM;
            default:
                state_next = ibc_pkg::ST_ACCUM;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ibc_pkg::ST_ACCUM:
            begin
                in_ready = 1'b1;
                cmd.acc  = in_valid;
            end
            ibc_pkg::ST_LOAD1: cmd.load1 = 1'b1;
            ibc_pkg::ST_DIV1:  cmd.step  = 1'b1;
            ibc_pkg::ST_LOAD2: cmd.load2 = 1'b1;
            ibc_pkg::ST_DIV2:
            begin
                cmd.step = 1'b1;
                cmd.sel2 = 1'b1;
            end
            ibc_pkg::ST_FIN:   cmd.res_load = out_free;
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.res_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ibc_pkg::ST_ACCUM;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== sv/imu_bias_calibration_top.sv =====
// ============================================================================
// imu_bias_calibration_top
// Accel and gyro bias calibration over batches of IMU frames.
// ============================================================================
// Frames are taken one per cycle while a batch fills. The beat that completes
// a batch of SAMPLE_COUNT frames starts the offset computation; no frame is
// taken in LOAD1, DIV1, LOAD2, DIV2 or FIN (FIN waits on a pending result):
// six divider lanes load the sum magnitudes and multiply them by a scaled
// reciprocal of SAMPLE_COUNT to form the axis averages, then the gyro lanes
// load |avg| * 32 and multiply by a scaled reciprocal of 131, and FIN builds
// the offset words. The finished words sit in an output register, so frames
// of the next batch flow in while a result waits. Factory accel words are
// written over the config port (index 0..2 for x, y, z; other indexes are
// ignored) while the block is idle: a user rule the block does not enforce.
// ============================================================================
module imu_bias_calibration_top #(
    parameter int SAMPLE_COUNT = ibc_pkg::SAMPLE_COUNT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ibc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ibc_pkg::WORD_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [ibc_pkg::IN_W-1:0]  accel_x,
    input  logic signed [ibc_pkg::IN_W-1:0]  accel_y,
    input  logic signed [ibc_pkg::IN_W-1:0]  accel_z,
    input  logic signed [ibc_pkg::IN_W-1:0]  gyro_x,
    input  logic signed [ibc_pkg::IN_W-1:0]  gyro_y,
    input  logic signed [ibc_pkg::IN_W-1:0]  gyro_z,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [ibc_pkg::WORD_W-1:0]       accel_offset_x,
    output logic [ibc_pkg::WORD_W-1:0]       accel_offset_y,
    output logic [ibc_pkg::WORD_W-1:0]       accel_offset_z,
    output logic [ibc_pkg::WORD_W-1:0]       gyro_offset_x,
    output logic [ibc_pkg::WORD_W-1:0]       gyro_offset_y,
    output logic [ibc_pkg::WORD_W-1:0]       gyro_offset_z
);

    ibc_pkg::ibc_cmd_t               cmd;
    ibc_pkg::ibc_status_t            status;
    logic signed [ibc_pkg::IN_W-1:0] frame [ibc_pkg::N_AXES];
    logic [ibc_pkg::WORD_W-1:0]      result [ibc_pkg::N_AXES];

    assign cfg_ready = 1'b1;

    assign frame[0] = accel_x;
    assign frame[1] = accel_y;
    assign frame[2] = accel_z;
    assign frame[3] = gyro_x;
    assign frame[4] = gyro_y;
    assign frame[5] = gyro_z;

    ibc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ibc_datapath #(
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .frame     (frame),
        .result    (result)
    );

    assign accel_offset_x = result[0];
    assign accel_offset_y = result[1];
    assign accel_offset_z = result[2];
    assign gyro_offset_x  = result[3];
    assign gyro_offset_y  = result[4];
    assign gyro_offset_z  = result[5];

`ifndef SYNTHESIS
    // The beat that completes a batch starts the divider load next cycle
    a_batch_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && status.last_frame |=> cmd.load1)
        else $error("batch completion did not start the divider");

    // A new result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> (!out_valid || out_ready))
        else $error("result register overwritten while pending");

    // Loading the result raises out_valid on the next cycle
    a_res_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |=> out_valid)
        else $error("result loaded without out_valid");

    // No frame is taken while the divider runs
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step || cmd.load1 || cmd.load2) |-> !in_ready)
        else $error("frame accepted during offset computation");
`endif

endmodule
